// File: rtl/core/slps_pkg.sv
`default_nettype none

package slps_pkg;

    localparam int unsigned MAX_FRAMES = 16384;
    localparam int unsigned TALLY_MAX  = 32767;
    localparam int unsigned FRAME_CAP  = (MAX_FRAMES < TALLY_MAX) ? MAX_FRAMES : TALLY_MAX;
    localparam int unsigned TALLY_W    = 15;
    localparam int unsigned SUM_W      = 30;
    localparam int unsigned TOTAL_W    = SUM_W + 1;
    localparam int unsigned DIV_STEPS  = TOTAL_W;
    localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

    localparam logic [1:0] GRP_ALL  = 2'd0;
    localparam logic [1:0] GRP_EVEN = 2'd1;
    localparam logic [1:0] GRP_ODD  = 2'd2;

    typedef struct packed {
        logic [TALLY_W-1:0] tally;
        logic signed [15:0] minv;
        logic signed [15:0] maxv;
        logic [SUM_W-1:0]   sum;
    } lane_stat_t;

    typedef struct packed {
        logic [15:0]        count;
        logic signed [15:0] minv;
        logic signed [15:0] maxv;
        logic [TOTAL_W-1:0] sum;
        logic [15:0]        peak;
    } grp_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SNAP,
        ST_START,
        ST_DIV,
        ST_LOAD
    } seq_state_t;

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        mag16 = v[15] ? 16'(-v) : 16'(v);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/slps_lane.sv
`default_nettype none

module slps_lane (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  wire logic               clear,
    input  wire logic signed [15:0] sample,
    output slps_pkg::lane_stat_t    stat
);
    import slps_pkg::*;

    lane_stat_t stat_reg;
    lane_stat_t stat_next;

    always_comb
    begin
        stat_next = stat_reg;
        if (clear)
        begin
            stat_next = '0;
        end
        else if (take)
        begin
            if (stat_reg.tally == '0)
            begin
                stat_next.minv = sample;
                stat_next.maxv = sample;
            end
            else
            begin
                if (sample < stat_reg.minv)
                begin
                    stat_next.minv = sample;
                end
                if (sample > stat_reg.maxv)
                begin
                    stat_next.maxv = sample;
                end
            end
            stat_next.sum   = stat_reg.sum + SUM_W'(mag16(sample));
            stat_next.tally = stat_reg.tally + TALLY_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg <= '0;
        end
        else
        begin
            stat_reg <= stat_next;
        end
    end

    assign stat = stat_reg;

endmodule

`default_nettype wire

// File: rtl/core/slps_merge.sv
`default_nettype none

module slps_merge (
    input  wire logic                 clk,
    input  wire logic                 capture,
    input  wire slps_pkg::lane_stat_t even_stat,
    input  wire slps_pkg::lane_stat_t odd_stat,
    output slps_pkg::grp_stat_t       all_grp,
    output slps_pkg::grp_stat_t       even_grp,
    output slps_pkg::grp_stat_t       odd_grp
);
    import slps_pkg::*;

    grp_stat_t all_reg;
    grp_stat_t even_reg;
    grp_stat_t odd_reg;
    grp_stat_t all_next;
    grp_stat_t even_next;
    grp_stat_t odd_next;

    function automatic grp_stat_t finish(input grp_stat_t g);
        grp_stat_t r;
        logic [15:0] mn;
        logic [15:0] mx;
        r  = g;
        mn = mag16(g.minv);
        mx = mag16(g.maxv);
        if (g.count == '0)
        begin
            r.minv = '0;
            r.maxv = '0;
            r.peak = '0;
        end
        else
        begin
            r.peak = (mn > mx) ? mn : mx;
        end
        finish = r;
    endfunction

    always_comb
    begin
        grp_stat_t a;
        grp_stat_t e;
        grp_stat_t o;

        e.count = 16'(even_stat.tally);
        e.minv  = even_stat.minv;
        e.maxv  = even_stat.maxv;
        e.sum   = TOTAL_W'(even_stat.sum);
        e.peak  = '0;

        o.count = 16'(odd_stat.tally);
        o.minv  = odd_stat.minv;
        o.maxv  = odd_stat.maxv;
        o.sum   = TOTAL_W'(odd_stat.sum);
        o.peak  = '0;

        a.count = e.count + o.count;
        a.sum   = e.sum + o.sum;
        a.peak  = '0;
        if (even_stat.tally == '0)
        begin
            a.minv = o.minv;
            a.maxv = o.maxv;
        end
        else if (odd_stat.tally == '0)
        begin
            a.minv = e.minv;
            a.maxv = e.maxv;
        end
        else
        begin
            a.minv = (e.minv < o.minv) ? e.minv : o.minv;
            a.maxv = (e.maxv > o.maxv) ? e.maxv : o.maxv;
        end

        all_next  = finish(a);
        even_next = finish(e);
        odd_next  = finish(o);
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            all_reg  <= all_next;
            even_reg <= even_next;
            odd_reg  <= odd_next;
        end
    end

    assign all_grp  = all_reg;
    assign even_grp = even_reg;
    assign odd_grp  = odd_reg;

endmodule

`default_nettype wire

// File: rtl/core/slps_div.sv
`default_nettype none

module slps_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [slps_pkg::TOTAL_W-1:0]    dividend,
    input  wire logic [15:0]                     divisor,
    output logic                                 done,
    output logic [15:0]                          quotient
);
    import slps_pkg::*;

    logic [TOTAL_W-1:0] dq_reg;
    logic [15:0]        rem_reg;
    logic [15:0]        dvs_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               run_reg;
    logic               done_reg;
    logic [16:0]        trial;
    logic               qbit;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, dq_reg[TOTAL_W-1]};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            dq_reg  <= {dq_reg[TOTAL_W-2:0], qbit};
            rem_reg <= qbit ? 16'(trial - {1'b0, dvs_reg}) : trial[15:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg[15:0];

endmodule

`default_nettype wire

// File: rtl/core/stereo_pcm_level_stats_top.sv
`default_nettype none

// Stereo level meter. Each input item is one stereo frame; while a block is
// being gathered a frame is taken every cycle, the left sample in the even
// lane and the right sample (when present) in the odd lane. The frame marked
// tlast closes the block: three result items follow (all, even, odd samples)
// and frames are held off until the last of them is loaded, since the mean of
// each group goes in turn through one shared 31-step serial divider (the block
// is latched first, then each group has a division and a load that waits while
// the previous result is not taken). Once 16384 left samples have been gathered,
// further frames are dropped until tlast. An empty group reports all zeros.

module stereo_pcm_level_stats_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // left_sample, right_sample, right_present
    input  wire logic        s_axis_tlast,   // last_frame
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // count, min_value, max_value,
                                             // mean_abs, peak_abs
    output logic [1:0]       m_axis_tuser,   // group
    output logic             m_axis_tlast    // last_of_run
);
    import slps_pkg::*;

    seq_state_t  state_reg;
    seq_state_t  state_next;
    logic [1:0]  grp_reg;
    logic        m_valid_reg;
    logic [79:0] out_data_reg;
    logic [1:0]  out_user_reg;
    logic        out_last_reg;

    logic        in_acc;
    logic        full;
    logic        lane_clear;
    logic        capture;
    logic        div_start;
    logic        div_done;
    logic        out_load;
    logic [15:0] quotient;
    logic [15:0] mean;

    lane_stat_t  even_stat;
    lane_stat_t  odd_stat;
    grp_stat_t   all_grp;
    grp_stat_t   even_grp;
    grp_stat_t   odd_grp;
    grp_stat_t   sel_grp;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign full   = (even_stat.tally >= TALLY_W'(FRAME_CAP));

    slps_lane u_even (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (in_acc && !full),
        .clear  (lane_clear),
        .sample (s_axis_tdata[15:0]),
        .stat   (even_stat)
    );

    slps_lane u_odd (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (in_acc && !full && s_axis_tdata[32]),
        .clear  (lane_clear),
        .sample (s_axis_tdata[31:16]),
        .stat   (odd_stat)
    );

    slps_merge u_merge (
        .clk       (clk),
        .capture   (capture),
        .even_stat (even_stat),
        .odd_stat  (odd_stat),
        .all_grp   (all_grp),
        .even_grp  (even_grp),
        .odd_grp   (odd_grp)
    );

    always_comb
    begin
        case (grp_reg)
            GRP_ALL:  sel_grp = all_grp;
            GRP_EVEN: sel_grp = even_grp;
            default:  sel_grp = odd_grp;
        endcase
    end

    slps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sel_grp.sum),
        .divisor  (sel_grp.count),
        .done     (div_done),
        .quotient (quotient)
    );

    assign mean = (sel_grp.count == '0) ? 16'd0 : quotient;

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        lane_clear    = 1'b0;
        capture       = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_acc && s_axis_tlast)
                begin
                    state_next = ST_SNAP;
                end
            end
            ST_SNAP:
            begin
                capture    = 1'b1;
                lane_clear = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = (grp_reg == GRP_ODD) ? ST_IDLE : ST_START;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            grp_reg     <= GRP_ALL;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
                grp_reg     <= (grp_reg == GRP_ODD) ? GRP_ALL : grp_reg + 2'd1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {sel_grp.peak, mean, sel_grp.maxv, sel_grp.minv, sel_grp.count};
            out_user_reg <= grp_reg;
            out_last_reg <= (grp_reg == GRP_ODD);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire
